FILE: src/dset_pkg.sv
`default_nettype none

package dset_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int ID_W     = 16;
   localparam int DATE_W   = 25;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;

   // a listing reports at most this many entries
   localparam int MAX_RESULTS = 32;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXISTS    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_LIST_ALL  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LIST_DATE = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;

   // one table entry
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [DATE_W-1:0]   date;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   // result item offered by the sequencer to the output register
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic                found;
      entry_type           entry;
      logic                last;
   } emit_type;

endpackage

`default_nettype wire

FILE: src/dset_ctrl.sv
`default_nettype none

module dset_ctrl #(
   parameter int CAPACITY = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dset_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [dset_pkg::ID_W-1:0]     req_event_id,
   input  wire logic [dset_pkg::DATE_W-1:0]   req_event_date,
   input  wire logic [dset_pkg::HANDLE_W-1:0] req_event_handle,
   output dset_pkg::emit_type                 emit,
   input  wire logic                          emit_ready
);

   import dset_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_INS_SHIFT = 8'b0000_0010,
      S_INS_PLACE = 8'b0000_0100,
      S_SCAN      = 8'b0000_1000,
      S_REM_SHIFT = 8'b0001_0000,
      S_BSEARCH   = 8'b0010_0000,
      S_LIST      = 8'b0100_0000,
      S_RESP      = 8'b1000_0000
   } state_type;

   // midpoint of the half-open range [lo, hi1)
   function automatic idx_type bs_mid(input cnt_type lo, input cnt_type hi1);
      logic [CNT_W:0] sum;
      begin
         sum = {1'b0, lo} + {1'b0, hi1} - (CNT_W + 1)'(1);
         return sum[IDX_W:1];
      end
   endfunction

   state_type               state_ff, state_in;
   cnt_type                 count_ff, count_in;
   idx_type                 pos_ff, pos_in;
   idx_type                 idx_ff, idx_in;
   idx_type                 mid_ff, mid_in;
   cnt_type                 lo_ff, lo_in;
   cnt_type                 hi1_ff, hi1_in;
   logic [RES_CNT_W-1:0]    n_ff, n_in;
   logic [KIND_W-1:0]       item_kind_ff, item_kind_in;
   entry_type               item_entry_ff, item_entry_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    res_found_ff, res_found_in;
   entry_type               res_entry_ff, res_entry_in;

   // table memory, one read and one write port
   entry_type               mem_ff [CAPACITY];
   entry_type               rd_data_ff;
   logic                    rd_en;
   idx_type                 rd_addr;
   logic                    wr_en;
   idx_type                 wr_addr;
   entry_type               wr_data;

   // step helpers
   cnt_type                 idx_next_c;
   logic                    match_c;
   logic                    adv_c;
   logic                    found_c;
   idx_type                 hit_c;
   cnt_type                 lo_c;
   cnt_type                 hi1_c;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      mid_in        = mid_ff;
      lo_in         = lo_ff;
      hi1_in        = hi1_ff;
      n_in          = n_ff;
      item_kind_in  = item_kind_ff;
      item_entry_in = item_entry_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_entry_in  = res_entry_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = item_entry_ff;
      emit          = '0;
      idx_next_c    = cnt_type'(idx_ff) + cnt_type'(1);
      match_c       = 1'b0;
      adv_c         = 1'b0;
      found_c       = 1'b0;
      hit_c         = pos_ff;
      lo_c          = lo_ff;
      hi1_c         = hi1_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_kind_in  = req_kind;
               item_entry_in = '{id: req_event_id, date: req_event_date,
                                 handle: req_event_handle};
               res_status_in = ST_OK;
               res_found_in  = 1'b0;
               res_entry_in  = '0;
               n_in          = '0;
               idx_in        = '0;
               case (req_kind)
                  KIND_INSERT: begin
                     if (count_ff >= cnt_type'(CAPACITY)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else if (count_ff == '0) begin
                        pos_in   = '0;
                        state_in = S_INS_PLACE;
                     end else begin
                        pos_in   = count_ff[IDX_W-1:0];
                        rd_en    = 1'b1;
                        rd_addr  = pos_in - idx_type'(1);
                        state_in = S_INS_SHIFT;
                     end
                  end
                  KIND_REMOVE, KIND_LOOKUP: begin
                     res_status_in = ST_NOTFOUND;
                     if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  KIND_EXISTS: begin
                     res_status_in = ST_NOTFOUND;
                     lo_in         = '0;
                     hi1_in        = count_ff;
                     if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        mid_in   = bs_mid('0, count_ff);
                        rd_en    = 1'b1;
                        rd_addr  = mid_in;
                        state_in = S_BSEARCH;
                     end
                  end
                  KIND_LIST_ALL, KIND_LIST_DATE: begin
                     if (req_kind == KIND_LIST_DATE) begin
                        res_status_in = ST_NOTFOUND;
                     end
                     if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // read data holds entry pos-1; move it up or drop the new item in
         S_INS_SHIFT: begin
            wr_en = 1'b1;
            if (item_entry_ff.date <= rd_data_ff.date) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - idx_type'(1);
               if (pos_ff == idx_type'(1)) begin
                  state_in = S_INS_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_in - idx_type'(1);
               end
            end else begin
               count_in = count_ff + cnt_type'(1);
               state_in = S_RESP;
            end
         end

         S_INS_PLACE: begin
            wr_en    = 1'b1;
            count_in = count_ff + cnt_type'(1);
            state_in = S_RESP;
         end

         // linear scan for the last entry with a matching id
         S_SCAN: begin
            match_c = (rd_data_ff.id == item_entry_ff.id);
            found_c = match_c || res_found_ff;
            if (match_c) begin
               res_status_in = ST_OK;
               res_found_in  = 1'b1;
               res_entry_in  = rd_data_ff;
               pos_in        = idx_ff;
               hit_c         = idx_ff;
            end
            if (idx_next_c != count_ff) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + idx_type'(1);
               idx_in  = rd_addr;
            end else if (item_kind_ff == KIND_REMOVE && found_c) begin
               count_in = count_ff - cnt_type'(1);
               if (cnt_type'(hit_c) < count_in) begin
                  rd_en    = 1'b1;
                  rd_addr  = hit_c + idx_type'(1);
                  state_in = S_REM_SHIFT;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_RESP;
            end
         end

         // close the gap: entry pos+1 moves down to pos
         S_REM_SHIFT: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            if (cnt_type'(pos_ff) + cnt_type'(1) < count_ff) begin
               pos_in  = pos_ff + idx_type'(1);
               rd_en   = 1'b1;
               rd_addr = pos_ff + idx_type'(2);
            end else begin
               state_in = S_RESP;
            end
         end

         // one probe per cycle over the sorted dates
         S_BSEARCH: begin
            if (rd_data_ff.date == item_entry_ff.date) begin
               res_status_in = ST_OK;
               res_found_in  = 1'b1;
               res_entry_in  = '{id: '0, date: item_entry_ff.date, handle: '0};
               state_in      = S_RESP;
            end else begin
               if (rd_data_ff.date > item_entry_ff.date) begin
                  hi1_c = cnt_type'(mid_ff);
               end else begin
                  lo_c = cnt_type'(mid_ff) + cnt_type'(1);
               end
               lo_in  = lo_c;
               hi1_in = hi1_c;
               if (lo_c < hi1_c) begin
                  mid_in  = bs_mid(lo_c, hi1_c);
                  rd_en   = 1'b1;
                  rd_addr = mid_in;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         // listing: newest match is held back so the final one gets last
         S_LIST: begin
            match_c = (item_kind_ff == KIND_LIST_ALL) ||
                      (rd_data_ff.date == item_entry_ff.date);
            if (match_c && res_found_ff) begin
               emit.valid  = 1'b1;
               emit.status = res_status_ff;
               emit.found  = res_found_ff;
               emit.entry  = res_entry_ff;
               emit.last   = 1'b0;
               adv_c       = emit_ready;
            end else begin
               adv_c = 1'b1;
            end
            if (adv_c) begin
               if (match_c) begin
                  res_status_in = ST_OK;
                  res_found_in  = 1'b1;
                  res_entry_in  = rd_data_ff;
                  n_in          = n_ff + RES_CNT_W'(1);
               end
               if ((idx_next_c == count_ff) ||
                   (match_c && n_in == RES_CNT_W'(MAX_RESULTS))) begin
                  state_in = S_RESP;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + idx_type'(1);
                  idx_in  = rd_addr;
               end
            end
         end

         // final result of the item
         S_RESP: begin
            emit.valid  = 1'b1;
            emit.status = res_status_ff;
            emit.found  = res_found_ff;
            emit.entry  = res_entry_ff;
            emit.last   = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      mid_ff        <= mid_in;
      lo_ff         <= lo_in;
      hi1_ff        <= hi1_in;
      n_ff          <= n_in;
      item_kind_ff  <= item_kind_in;
      item_entry_ff <= item_entry_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_entry_ff  <= res_entry_in;
   end

endmodule

`default_nettype wire

FILE: src/date_sorted_event_table.sv
`default_nettype none

// Channel  Ports                                        Direction  Moves
// req      req_valid/ready, kind, event_id/date/handle  in         one operation item
// rsp      rsp_valid/ready, status, found, out_*, last  out        result items
//
// Entries sit in one memory, one read and one write per cycle. Insert, lookup and
// listings step through the entries one at a time, remove scans and then closes
// the gap, and date exists runs a binary search over the sorted dates.
// Reset clears the entry count, the sequencer state and the result valid; the memory keeps its contents.
// A stalled result register holds back listings; other items wait at the end.
// req_ready is high only while no item is in progress.
module date_sorted_event_table #(
   parameter int CAPACITY = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dset_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [dset_pkg::ID_W-1:0]     req_event_id,
   input  wire logic [dset_pkg::DATE_W-1:0]   req_event_date,
   input  wire logic [dset_pkg::HANDLE_W-1:0] req_event_handle,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dset_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_found,
   output logic [dset_pkg::ID_W-1:0]          rsp_out_id,
   output logic [dset_pkg::DATE_W-1:0]        rsp_out_date,
   output logic [dset_pkg::HANDLE_W-1:0]      rsp_out_handle,
   output logic                               rsp_last
);

   import dset_pkg::*;

   emit_type            emit;
   logic                slot_free;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_found_ff;
   entry_type           rsp_entry_ff;
   logic                rsp_last_ff;

   dset_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_event_id     (req_event_id),
      .req_event_date   (req_event_date),
      .req_event_handle (req_event_handle),
      .emit             (emit),
      .emit_ready       (slot_free)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid && slot_free) begin
         rsp_status_ff <= emit.status;
         rsp_found_ff  <= emit.found;
         rsp_entry_ff  <= emit.entry;
         rsp_last_ff   <= emit.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_out_id     = rsp_entry_ff.id;
   assign rsp_out_date   = rsp_entry_ff.date;
   assign rsp_out_handle = rsp_entry_ff.handle;
   assign rsp_last       = rsp_last_ff;

   // checks
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !emit.valid)
      else $error("result offered while a new item is accepted");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.last && slot_free) |=> req_ready)
      else $error("block not ready after final result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_out_id == '0 && rsp_out_date == '0 && rsp_out_handle == '0))
      else $error("result without entry carries nonzero fields");

   a_full_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (!rsp_found && rsp_last))
      else $error("table-full result malformed");

endmodule

`default_nettype wire

FILE: sim/date_sorted_event_table_tb.sv
module date_sorted_event_table_tb;
   import dset_pkg::*;

   localparam int CAP         = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 5000;
   localparam int RUN_LIMIT   = 25_000_000;

   // kinds the block does not define; it answers them with a plain ok
   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

   localparam logic [DATE_W-1:0] D_MAX = 25'h1FFFFFF;
   localparam logic [DATE_W-1:0] D_MID = 25'h0BB8EF;

   // one operation; typed_in marks rows whose single result is spelled out
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [ID_W-1:0]     id;
      logic [DATE_W-1:0]   date;
      logic [HANDLE_W-1:0] handle;
      logic                typed_in;
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [DATE_W-1:0]   out_date;
   } op_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [ID_W-1:0]     id;
      logic [DATE_W-1:0]   date;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind;
   logic [ID_W-1:0]     req_event_id;
   logic [DATE_W-1:0]   req_event_date;
   logic [HANDLE_W-1:0] req_event_handle;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [ID_W-1:0]     rsp_out_id;
   logic [DATE_W-1:0]   rsp_out_date;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic                rsp_last;

   // predicted table contents
   logic [ID_W-1:0]     tbl_id     [CAP];
   logic [DATE_W-1:0]   tbl_date   [CAP];
   logic [HANDLE_W-1:0] tbl_handle [CAP];
   int                  tbl_count;

   result_type step_out[$];         // results of the operation just applied
   result_type pending_results[$];  // results still owed by the block
   int         errors;
   int         result_num;

   // stimulus shaping, written by the main process
   bit req_no_gaps;
   bit rsp_always_ready;
   bit rsp_hold_req;

   // directed operations: empty table, extremes, ties, duplicate ids, spare kinds
   op_row_type dir_tab [25] = '{
      '{KIND_LIST_ALL,  16'h0000, 25'h0,     16'h0000, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_LIST_DATE, 16'h0000, 25'h0,     16'h0000, 1'b1, ST_NOTFOUND, 1'b0, 25'h0},
      '{KIND_LOOKUP,    16'h0000, 25'h0,     16'h0000, 1'b1, ST_NOTFOUND, 1'b0, 25'h0},
      '{KIND_REMOVE,    16'hFFFF, D_MAX,     16'hFFFF, 1'b1, ST_NOTFOUND, 1'b0, 25'h0},
      '{KIND_EXISTS,    16'h0000, 25'h0,     16'h0000, 1'b1, ST_NOTFOUND, 1'b0, 25'h0},
      '{KIND_SPARE_A,   16'hFFFF, D_MAX,     16'hFFFF, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_SPARE_B,   16'h0000, 25'h0,     16'h0000, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_INSERT,    16'hFFFF, D_MAX,     16'hFFFF, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_INSERT,    16'h0000, 25'h0,     16'h0000, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_INSERT,    16'h1234, D_MAX,     16'h5555, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_INSERT,    16'hAAAA, D_MID,     16'h00FF, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_EXISTS,    16'h0000, D_MAX,     16'h0000, 1'b1, ST_OK,       1'b1, D_MAX},
      '{KIND_EXISTS,    16'h0000, 25'h0,     16'h0000, 1'b1, ST_OK,       1'b1, 25'h0},
      '{KIND_EXISTS,    16'h0000, D_MID + 25'd1, 16'h0000, 1'b1, ST_NOTFOUND, 1'b0, 25'h0},
      '{KIND_LIST_ALL,  16'h0000, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_LIST_DATE, 16'h0000, D_MAX,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_LOOKUP,    16'hFFFF, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_INSERT,    16'h1234, 25'h0,     16'h0001, 1'b1, ST_OK,       1'b0, 25'h0},
      '{KIND_LOOKUP,    16'h1234, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_REMOVE,    16'h1234, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_REMOVE,    16'h1234, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_LIST_ALL,  16'h0000, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_REMOVE,    16'h0000, 25'h0,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_LIST_DATE, 16'h0000, D_MID,     16'h0000, 1'b0, ST_OK,       1'b0, 25'h0},
      '{KIND_EXISTS,    16'h0000, D_MID,     16'h0000, 1'b1, ST_OK,       1'b1, D_MID}
   };

   date_sorted_event_table #(.CAPACITY(CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_event_id     (req_event_id),
      .req_event_date   (req_event_date),
      .req_event_handle (req_event_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_date     (rsp_out_date),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT);
      $display("date_sorted_event_table_tb failed");
      $finish;
   end

   // apply one operation to the predicted table, leaving its results in step_out
   function automatic void apply_to_table(input op_row_type op);
      result_type r;
      int         pos, hit, lo, hi, mid, i;
      bit         seen;
      step_out.delete();
      r = '0;
      case (op.kind)
         KIND_INSERT: begin
            if (tbl_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               // shift up everything at or after the new date
               pos = tbl_count;
               while (pos > 0 && op.date <= tbl_date[pos - 1]) begin
                  tbl_id[pos]     = tbl_id[pos - 1];
                  tbl_date[pos]   = tbl_date[pos - 1];
                  tbl_handle[pos] = tbl_handle[pos - 1];
                  pos--;
               end
               tbl_id[pos]     = op.id;
               tbl_date[pos]   = op.date;
               tbl_handle[pos] = op.handle;
               tbl_count++;
               r.status = ST_OK;
            end
            step_out.push_back(r);
         end
         KIND_REMOVE, KIND_LOOKUP: begin
            hit = -1;
            for (i = 0; i < tbl_count; i++)
               if (tbl_id[i] == op.id) hit = i;
            if (hit < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               r.status = ST_OK;
               r.found  = 1'b1;
               r.id     = tbl_id[hit];
               r.date   = tbl_date[hit];
               r.handle = tbl_handle[hit];
               if (op.kind == KIND_REMOVE) begin
                  for (i = hit; i + 1 < tbl_count; i++) begin
                     tbl_id[i]     = tbl_id[i + 1];
                     tbl_date[i]   = tbl_date[i + 1];
                     tbl_handle[i] = tbl_handle[i + 1];
                  end
                  tbl_count--;
               end
            end
            step_out.push_back(r);
         end
         KIND_EXISTS: begin
            seen = 1'b0;
            lo   = 0;
            hi   = tbl_count - 1;
            while (lo <= hi && !seen) begin
               mid = (lo + hi) / 2;
               if (tbl_date[mid] == op.date) seen = 1'b1;
               else if (tbl_date[mid] > op.date) hi = mid - 1;
               else lo = mid + 1;
            end
            if (seen) begin
               r.status = ST_OK;
               r.found  = 1'b1;
               r.date   = op.date;
            end else begin
               r.status = ST_NOTFOUND;
            end
            step_out.push_back(r);
         end
         KIND_LIST_ALL, KIND_LIST_DATE: begin
            for (i = 0; i < tbl_count && step_out.size() < MAX_RESULTS; i++) begin
               if (op.kind == KIND_LIST_ALL || tbl_date[i] == op.date) begin
                  r.status = ST_OK;
                  r.found  = 1'b1;
                  r.id     = tbl_id[i];
                  r.date   = tbl_date[i];
                  r.handle = tbl_handle[i];
                  step_out.push_back(r);
               end
            end
            if (step_out.size() == 0) begin
               r.status = (op.kind == KIND_LIST_ALL) ? ST_OK : ST_NOTFOUND;
               step_out.push_back(r);
            end
         end
         default: begin
            r.status = ST_OK;
            step_out.push_back(r);
         end
      endcase
      r = step_out.pop_back();
      r.last = 1'b1;
      step_out.push_back(r);
   endfunction

   // random operation; ids and dates lean on what the table holds
   function automatic op_row_type random_op(input int ins_pct);
      op_row_type op;
      int         r;
      op = '0;
      op.handle = HANDLE_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
         op.kind = KIND_INSERT;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 25) op.kind = KIND_REMOVE;
         else if (r < 45) op.kind = KIND_LOOKUP;
         else if (r < 65) op.kind = KIND_EXISTS;
         else if (r < 77) op.kind = KIND_LIST_ALL;
         else if (r < 92) op.kind = KIND_LIST_DATE;
         else if (r < 96) op.kind = KIND_SPARE_A;
         else op.kind = KIND_SPARE_B;
      end
      if (tbl_count > 0 && $urandom_range(0, 2) != 0)
         op.id = tbl_id[$urandom_range(0, tbl_count - 1)];
      else
         op.id = ID_W'($urandom);
      r = $urandom_range(0, 9);
      if (tbl_count > 0 && r < 4)
         op.date = tbl_date[$urandom_range(0, tbl_count - 1)];
      else if (tbl_count > 0 && r == 4)
         op.date = tbl_date[$urandom_range(0, tbl_count - 1)] + 1'b1;
      else if (r < 7)
         op.date = DATE_W'($urandom_range(0, 3)) << 9;  // few dates, many ties
      else if (r < 9)
         op.date = DATE_W'($urandom);
      else
         op.date = $urandom_range(0, 1) ? D_MAX : '0;
      return op;
   endfunction

   // offer one item, hold it until accepted, then record what it should produce
   task automatic send_op(input op_row_type op);
      result_type typed_res;
      @(negedge clock);
      req_valid        = 1'b1;
      req_kind         = op.kind;
      req_event_id     = op.id;
      req_event_date   = op.date;
      req_event_handle = op.handle;
      do @(posedge clock); while (!req_ready);
      apply_to_table(op);
      if (op.typed_in) begin
         typed_res        = '0;
         typed_res.status = op.status;
         typed_res.found  = op.found;
         typed_res.date   = op.out_date;
         typed_res.last   = 1'b1;
         pending_results.push_back(typed_res);
      end else begin
         foreach (step_out[i]) pending_results.push_back(step_out[i]);
      end
   endtask

   // idle the request side: mostly none or short, now and then long
   task automatic req_gap();
      int r, n;
      if (req_no_gaps) return;
      r = $urandom_range(0, 99);
      if (r < 55) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 30);
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop offering and wait for every owed result
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: result %0d %s expected %0h got %0h", $time, result_num, name,
                  want, got);
         errors++;
      end
   endtask

   // result side: compare each accepted item with the oldest prediction
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result %0d unexpected, nothing pending (status %0h id %0h)",
                     $time, result_num, rsp_status, rsp_out_id);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("out_id", 32'(want.id), 32'(rsp_out_id));
            check_field("out_date", 32'(want.date), 32'(rsp_out_date));
            check_field("out_handle", 32'(want.handle), 32'(rsp_out_handle));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
         result_num++;
      end
   end

   // result ready: random runs and stalls, an optional long hold, or always ready
   initial begin : rsp_side
      int run_left, stall_left, r;
      rsp_ready  = 1'b0;
      run_left   = 0;
      stall_left = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            stall_left   = HOLD_CYCLES;
            run_left     = 0;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (rsp_always_ready || run_left > 0) begin
            rsp_ready = 1'b1;
            if (run_left > 0) run_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_ready = 1'b1;
               run_left  = $urandom_range(0, 15);
            end else if (r < 92) begin
               rsp_ready  = 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_ready  = 1'b0;
               stall_left = $urandom_range(9, 29);
            end
         end
      end
   end

   initial begin : stimulus
      op_row_type op;
      int         i;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_INSERT;
      req_event_id     = '0;
      req_event_date   = '0;
      req_event_handle = '0;
      tbl_count        = 0;
      errors           = 0;
      result_num       = 0;
      req_no_gaps      = 1'b0;
      rsp_always_ready = 1'b0;
      rsp_hold_req     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (dir_tab[k]) begin
         send_op(dir_tab[k]);
         req_gap();
      end
      drain();

      // fill the table with many equal dates, then overflow it
      while (tbl_count < CAP) begin
         send_op(random_op(80));
         req_gap();
      end
      for (i = 0; i < 3; i++) begin
         send_op(random_op(100));
         req_gap();
      end
      drain();

      // long result hold-off on a full table while items keep coming
      rsp_hold_req = 1'b1;
      req_no_gaps  = 1'b1;
      op = '0;
      op.kind = KIND_LIST_ALL;
      send_op(op);
      op.kind = KIND_LIST_DATE;
      op.date = tbl_date[$urandom_range(0, CAP - 1)];
      send_op(op);
      send_op(random_op(0));
      send_op(random_op(100));
      send_op(random_op(0));
      op.kind = KIND_LIST_ALL;
      send_op(op);
      req_no_gaps = 1'b0;
      drain();

      // mixed traffic, with a stretch of no idling on either side
      for (i = 0; i < 110; i++) begin
         if (i == 40) begin
            req_no_gaps      = 1'b1;
            rsp_always_ready = 1'b1;
         end
         if (i == 70) begin
            req_no_gaps      = 1'b0;
            rsp_always_ready = 1'b0;
         end
         send_op(random_op(40));
         req_gap();
      end
      drain();

      // empty the table by id, listing now and then
      i = 0;
      while (tbl_count > 0) begin
         op = '0;
         op.handle = HANDLE_W'($urandom);
         op.date   = DATE_W'($urandom);
         if (i % 6 == 5) begin
            op.kind = KIND_LIST_ALL;
         end else begin
            op.kind = KIND_REMOVE;
            op.id   = tbl_id[$urandom_range(0, tbl_count - 1)];
         end
         send_op(op);
         req_gap();
         i++;
      end
      op = '0;
      op.kind = KIND_LIST_ALL;
      send_op(op);
      op.kind = KIND_LIST_DATE;
      send_op(op);
      op.kind = KIND_EXISTS;
      send_op(op);

      // a last random stretch from the empty table
      for (i = 0; i < 20; i++) begin
         send_op(random_op(50));
         req_gap();
      end

      // wait out the owed results, then watch for strays
      @(negedge clock);
      req_valid = 1'b0;
      for (i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
         @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         errors++;
      end
      repeat (2 * CAP + 10) @(posedge clock);
      if (errors == 0)
         $display("date_sorted_event_table_tb passed");
      else
         $display("date_sorted_event_table_tb failed");
      $finish;
   end

endmodule

FILE: filelist.f
src/dset_pkg.sv
src/dset_ctrl.sv
src/date_sorted_event_table.sv
sim/date_sorted_event_table_tb.sv
